[hw/rtl/picp_pkg.sv]
package picp_pkg;

	// table and coordinate sizes
	localparam int MAX_VERTICES = 64;
	localparam int COORD_WIDTH  = 32;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_WIDTH + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// smallest polygon
	localparam logic [CNT_W-1:0] MIN_VERTICES = CNT_W'(3);

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// control from sequencer to the shared multiply/compare unit
	typedef struct packed {
		logic sel_second;   // 0: (by-ay)*(px-ax), 1: (bx-ax)*(py-ay)
		logic save_first;   // park the first product for the compare
	} unit_ctrl_t;

endpackage

[hw/rtl/point_in_convex_polygon_unit.sv]
// Convex polygon containment, one shared multiplier stepped per edge.
//
// Input: an item is transferred at a rising edge with start high and busy
// low. operation selects a vertex load (coord_x/coord_y written to slot
// vertex_index, done in that cycle, no result) or a point query.
// Config: vertex_count is written on any edge with cfg_we high; values
// below 3 act as 3, above 64 as 64. Write it only while idle.
// Output: a query yields one transfer: done high for one cycle with
// inside_res valid (1 = on or inside every edge). The receiver cannot
// stall, so the strobe is never held.
// Sequence: a query keeps busy high through RD0, LD_A and LD_B, which prime
// the vertex table read, then through MUL1, MUL2 and CMP per edge, since the
// one multiplier forms both cross products in turn and a compare follows.
// It stops at the first edge that puts the point outside. done is high in
// the first cycle with busy low, and a new item may be transferred in that
// cycle. Loads complete at their transfer and may follow back to back.
// Reset: vertex_count returns to 3, the sequencer idles. The vertex table
// is not cleared; every vertex in use must be loaded before a query.
module point_in_convex_polygon_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [5:0]                          vertex_index,
	input  logic signed [31:0]                  coord_x,
	input  logic signed [31:0]                  coord_y,
	input  logic                                cfg_we,
	input  logic [6:0]                          cfg_wdata,
	output logic                                done,
	output logic                                inside_res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_LD_A,
		ST_LD_B,
		ST_MUL1,
		ST_MUL2,
		ST_CMP
	} state_t;

	state_t                              state_q;
	logic [picp_pkg::CNT_W-1:0]          vcount_q;
	logic [picp_pkg::CNT_W-1:0]          n_q;
	logic [picp_pkg::CNT_W-1:0]          n_use;
	logic [picp_pkg::ADDR_W-1:0]         k_q;
	logic [picp_pkg::ADDR_W-1:0]         k_next;
	logic [picp_pkg::CNT_W-1:0]          k_inc;
	logic [picp_pkg::ADDR_W-1:0]         e_q;
	logic                                last_edge;
	picp_pkg::coord_t                    px_q, py_q;
	picp_pkg::coord_t                    ax_q, ay_q, bx_q, by_q;
	picp_pkg::coord_t                    rd_x, rd_y;
	logic                                done_q, inside_q;
	logic                                take;
	logic                                wr_en;
	logic                                positive;
	picp_pkg::unit_ctrl_t                uctrl;

	assign busy       = (state_q != ST_IDLE);
	assign take       = start && !busy;
	assign wr_en      = take && (operation == picp_pkg::OP_LOAD);
	assign done       = done_q;
	assign inside_res = inside_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= picp_pkg::MIN_VERTICES;
		end else if (cfg_we) begin
			vcount_q <= picp_pkg::CNT_W'(cfg_wdata);
		end
	end

	// clamp the vertex count into range
	always_comb begin
		if (vcount_q < picp_pkg::MIN_VERTICES) begin
			n_use = picp_pkg::MIN_VERTICES;
		end else if (vcount_q > picp_pkg::CNT_W'(picp_pkg::MAX_VERTICES)) begin
			n_use = picp_pkg::CNT_W'(picp_pkg::MAX_VERTICES);
		end else begin
			n_use = vcount_q;
		end
	end

	// read address wraps from the last vertex back to vertex 0
	assign k_inc     = picp_pkg::CNT_W'(k_q) + picp_pkg::CNT_W'(1);
	assign k_next    = (k_inc == n_q) ? '0 : k_inc[picp_pkg::ADDR_W-1:0];
	assign last_edge = ((picp_pkg::CNT_W'(e_q) + picp_pkg::CNT_W'(1)) == n_q);

	// unit control
	assign uctrl.sel_second = (state_q == ST_MUL2);
	assign uctrl.save_first = (state_q == ST_MUL2);

	picp_vertex_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (vertex_index),
		.wr_x    (coord_x),
		.wr_y    (coord_y),
		.rd_addr (k_q),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	picp_edge_unit u_edge (
		.clk      (clk),
		.ctrl     (uctrl),
		.a_x      (ax_q),
		.a_y      (ay_q),
		.b_x      (bx_q),
		.b_y      (by_q),
		.p_x      (px_q),
		.p_y      (py_q),
		.positive (positive)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= picp_pkg::MIN_VERTICES;
			k_q      <= '0;
			e_q      <= '0;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
			px_q     <= '0;
			py_q     <= '0;
			ax_q     <= '0;
			ay_q     <= '0;
			bx_q     <= '0;
			by_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take && (operation == picp_pkg::OP_QUERY)) begin
						px_q    <= coord_x;
						py_q    <= coord_y;
						n_q     <= n_use;
						k_q     <= '0;
						e_q     <= '0;
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					k_q     <= k_next;
					state_q <= ST_LD_A;
				end
				ST_LD_A: begin
					ax_q    <= rd_x;
					ay_q    <= rd_y;
					k_q     <= k_next;
					state_q <= ST_LD_B;
				end
				// hold the address: the third vertex is read during the products
				ST_LD_B: begin
					bx_q    <= rd_x;
					by_q    <= rd_y;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (positive || last_edge) begin
						done_q   <= 1'b1;
						inside_q <= !positive;
						state_q  <= ST_IDLE;
					end else begin
						ax_q    <= bx_q;
						ay_q    <= by_q;
						bx_q    <= rd_x;
						by_q    <= rd_y;
						k_q     <= k_next;
						e_q     <= e_q + 1'b1;
						state_q <= ST_MUL1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result only ends a query in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a query in progress");

	// a query transfer starts the sequencer
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (operation == picp_pkg::OP_QUERY)) |=> busy)
		else $error("query transfer did not start the sequencer");

	// edge counter stays below the vertex count
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (picp_pkg::CNT_W'(e_q) < n_q))
		else $error("edge counter ran past the vertex count");

	// read address stays within the polygon
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (picp_pkg::CNT_W'(k_q) < n_q))
		else $error("vertex read address out of range");

endmodule

[hw/rtl/picp_vertex_mem.sv]
module picp_vertex_mem (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [picp_pkg::ADDR_W-1:0]    wr_addr,
	input  picp_pkg::coord_t               wr_x,
	input  picp_pkg::coord_t               wr_y,
	input  logic [picp_pkg::ADDR_W-1:0]    rd_addr,
	output picp_pkg::coord_t               rd_x,
	output picp_pkg::coord_t               rd_y
);

	picp_pkg::coord_t mem_x [picp_pkg::MAX_VERTICES];
	picp_pkg::coord_t mem_y [picp_pkg::MAX_VERTICES];
	picp_pkg::coord_t rd_x_q;
	picp_pkg::coord_t rd_y_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	assign rd_x = rd_x_q;
	assign rd_y = rd_y_q;

endmodule

[hw/rtl/picp_edge_unit.sv]
module picp_edge_unit (
	input  logic                  clk,
	input  picp_pkg::unit_ctrl_t  ctrl,
	input  picp_pkg::coord_t      a_x,
	input  picp_pkg::coord_t      a_y,
	input  picp_pkg::coord_t      b_x,
	input  picp_pkg::coord_t      b_y,
	input  picp_pkg::coord_t      p_x,
	input  picp_pkg::coord_t      p_y,
	output logic                  positive
);

	logic signed [picp_pkg::DIFF_W-1:0] op_a;
	logic signed [picp_pkg::DIFF_W-1:0] op_b;
	logic signed [picp_pkg::PROD_W-1:0] prod_q;
	logic signed [picp_pkg::PROD_W-1:0] first_q;

	// operand select: exact 33-bit differences
	always_comb begin
		if (ctrl.sel_second) begin
			op_a = picp_pkg::DIFF_W'(b_x) - picp_pkg::DIFF_W'(a_x);
			op_b = picp_pkg::DIFF_W'(p_y) - picp_pkg::DIFF_W'(a_y);
		end else begin
			op_a = picp_pkg::DIFF_W'(b_y) - picp_pkg::DIFF_W'(a_y);
			op_b = picp_pkg::DIFF_W'(p_x) - picp_pkg::DIFF_W'(a_x);
		end
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (ctrl.save_first) begin
			first_q <= prod_q;
		end
	end

	// edge value > 0 <=> first product > second product
	assign positive = (first_q > prod_q);

endmodule
